// ===== design/assert_macros.svh =====
// Shared assertion macros for the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while out of reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds while out of reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== design/ftc_pkg.sv =====
package ftc_pkg;

  localparam int unsigned NumFramesDef = 64;
  localparam int unsigned VpageBitsDef = 20;
  localparam int unsigned OwnerBitsDef = 8;

  localparam int unsigned ReqW    = 3;
  localparam int unsigned FrameW  = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  typedef enum logic [ReqW-1:0] {
    REQ_ALLOC  = 3'd0,
    REQ_PIN    = 3'd1,
    REQ_UNPIN  = 3'd2,
    REQ_FREE   = 3'd3,
    REQ_ACCESS = 3'd4
  } ftc_req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NO_EVICT = 2'd1,
    ST_RANGE    = 2'd2
  } ftc_status_e;

  // Per-frame flag word kept in the flag memory.
  typedef struct packed {
    logic used;
    logic pin;
    logic acc;
    logic dirty;
  } ftc_flags_t;

  localparam int unsigned FlagW = $bits(ftc_flags_t);

endpackage

// ===== design/frame_table_clock_replacer_core.sv =====
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+--------------------------------------------
// request  | in_valid_i / in_stall_o     | req_type_i frame_i vpage_i owner_i write_access_i
// result   | out_valid_o / out_stall_i   | status_o frame_out_o was_pinned_o unmap_*_o
// config   | cfg_we_i                    | cfg_wdata_i (frame_count)
//
// After reset a clearing pass over every frame zeroes the flag memory; no item is
// taken then. An in-range pin, unpin, free or access updates its flags in S_OP,
// then S_OUT loads the output register. Allocate scans the managed frames one frame a
// cycle, then runs the clock sweep, each frame read in S_SW_ISSUE, then modified and
// written back in S_SW_EVAL. One item is worked at a time; a result that cannot move
// into a stalled output register holds the core in S_OUT and blocks new items.
module frame_table_clock_replacer_core
  import ftc_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = ftc_pkg::NumFramesDef,
  parameter int unsigned VPAGE_BITS = ftc_pkg::VpageBitsDef,
  parameter int unsigned OWNER_BITS = ftc_pkg::OwnerBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ftc_pkg::ReqW-1:0]    req_type_i,
  input  logic [ftc_pkg::FrameW-1:0]  frame_i,
  input  logic [VPAGE_BITS-1:0]       vpage_i,
  input  logic [OWNER_BITS-1:0]       owner_i,
  input  logic                        write_access_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ftc_pkg::StatusW-1:0] status_o,
  output logic [ftc_pkg::FrameW-1:0]  frame_out_o,
  output logic                        was_pinned_o,
  output logic                        unmap_valid_o,
  output logic [VPAGE_BITS-1:0]       unmap_vpage_o,
  output logic [OWNER_BITS-1:0]       unmap_owner_o,
  output logic                        unmap_dirty_o,
  input  logic                        cfg_we_i,
  input  logic [ftc_pkg::CountW-1:0]  cfg_wdata_i
);

  `include "assert_macros.svh"

  localparam int unsigned IW   = $clog2(NUM_FRAMES);
  localparam int unsigned CW0  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned CMPW = (CW0 > CountW) ? CW0 : CountW;
  localparam int unsigned PW   = VPAGE_BITS + OWNER_BITS;

  localparam logic [2:0] S_CLR      = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SW_ISSUE = 3'd3;
  localparam logic [2:0] S_SW_EVAL  = 3'd4;
  localparam logic [2:0] S_OP       = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CountW-1:0]     count_q;
  logic [IW-1:0]         clr_q, clr_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         hand_q, hand_d;
  logic                  evict_q, evict_d;
  logic [ReqW-1:0]       req_q, req_d;
  logic                  wr_q, wr_d;
  logic [VPAGE_BITS-1:0] vpage_q, vpage_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;

  logic [StatusW-1:0]    res_status_q, res_status_d;
  logic [FrameW-1:0]     res_frame_q, res_frame_d;
  logic                  res_pin_q, res_pin_d;
  logic                  res_uv_q, res_uv_d;
  logic [VPAGE_BITS-1:0] res_vpage_q, res_vpage_d;
  logic [OWNER_BITS-1:0] res_owner_q, res_owner_d;
  logic                  res_dirty_q, res_dirty_d;
  logic                  out_valid_q;

  logic                  flag_we, pay_we;
  logic [IW-1:0]         flag_waddr, raddr;
  ftc_flags_t            flag_wdata, fl;
  logic [FlagW-1:0]      flag_rdata;
  logic [PW-1:0]         pay_rdata;

  logic [CMPW-1:0]       cnt, last, idx_ext, next_ext, hand_ext, f_ext;
  logic [IW-1:0]         next_idx, hand_start;
  logic                  accept, out_load;

  assign fl = ftc_flags_t'(flag_rdata);

  always_comb begin
    cnt = {{(CMPW-CountW){1'b0}}, count_q};
    if (count_q == '0) begin
      cnt = CMPW'(1);
    end else if (cnt > CMPW'(NUM_FRAMES)) begin
      cnt = CMPW'(NUM_FRAMES);
    end
  end

  assign last       = cnt - CMPW'(1);
  assign idx_ext    = {{(CMPW-IW){1'b0}}, idx_q};
  assign next_ext   = idx_ext + CMPW'(1);
  assign next_idx   = (next_ext >= cnt) ? '0 : next_ext[IW-1:0];
  assign hand_ext   = {{(CMPW-IW){1'b0}}, hand_q};
  assign hand_start = (hand_ext >= cnt) ? '0 : hand_q;
  assign f_ext      = {{(CMPW-FrameW){1'b0}}, frame_i};

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    idx_d        = idx_q;
    hand_d       = hand_q;
    evict_d      = evict_q;
    req_d        = req_q;
    wr_d         = wr_q;
    vpage_d      = vpage_q;
    owner_d      = owner_q;
    res_status_d = res_status_q;
    res_frame_d  = res_frame_q;
    res_pin_d    = res_pin_q;
    res_uv_d     = res_uv_q;
    res_vpage_d  = res_vpage_q;
    res_owner_d  = res_owner_q;
    res_dirty_d  = res_dirty_q;
    flag_we      = 1'b0;
    flag_waddr   = idx_q;
    flag_wdata   = fl;
    pay_we       = 1'b0;
    raddr        = idx_q;

    case (state_q)
      S_CLR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_q;
        flag_wdata = '0;
        clr_d      = clr_q + IW'(1);
        if (clr_q == IW'(NUM_FRAMES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_d        = req_type_i;
          wr_d         = write_access_i;
          vpage_d      = vpage_i;
          owner_d      = owner_i;
          evict_d      = 1'b0;
          res_status_d = ST_OK;
          res_frame_d  = '0;
          res_pin_d    = 1'b0;
          res_uv_d     = 1'b0;
          res_vpage_d  = '0;
          res_owner_d  = '0;
          res_dirty_d  = 1'b0;
          if (req_type_i == REQ_ALLOC) begin
            idx_d   = '0;
            raddr   = '0;
            state_d = S_SCAN;
          end else if (req_type_i == REQ_PIN || req_type_i == REQ_UNPIN ||
                       req_type_i == REQ_FREE || req_type_i == REQ_ACCESS) begin
            if (f_ext >= cnt) begin
              res_status_d = ST_RANGE;
              state_d      = S_OUT;
            end else begin
              idx_d   = f_ext[IW-1:0];
              raddr   = f_ext[IW-1:0];
              state_d = S_OP;
            end
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_SCAN: begin
        // Reads run one frame ahead of the frame being checked.
        raddr = next_ext[IW-1:0];
        if (!fl.used) begin
          flag_we     = 1'b1;
          flag_wdata  = '{used: 1'b1, pin: fl.pin, acc: 1'b0, dirty: 1'b0};
          pay_we      = 1'b1;
          res_frame_d = idx_ext[FrameW-1:0];
          state_d     = S_OUT;
        end else if (idx_ext == last) begin
          if (!(evict_q || !fl.pin)) begin
            res_status_d = ST_NO_EVICT;
            state_d      = S_OUT;
          end else begin
            idx_d   = hand_start;
            state_d = S_SW_ISSUE;
          end
        end else begin
          evict_d = evict_q || !fl.pin;
          idx_d   = next_ext[IW-1:0];
        end
      end
      S_SW_ISSUE: begin
        state_d = S_SW_EVAL;
      end
      S_SW_EVAL: begin
        idx_d   = next_idx;
        state_d = S_SW_ISSUE;
        if (fl.used && !fl.pin) begin
          flag_we = 1'b1;
          if (fl.acc) begin
            flag_wdata.acc = 1'b0;
          end else begin
            flag_wdata  = '{used: 1'b1, pin: fl.pin, acc: 1'b0, dirty: 1'b0};
            pay_we      = 1'b1;
            res_uv_d    = 1'b1;
            res_vpage_d = pay_rdata[PW-1:OWNER_BITS];
            res_owner_d = pay_rdata[OWNER_BITS-1:0];
            res_dirty_d = fl.dirty;
            res_frame_d = idx_ext[FrameW-1:0];
            hand_d      = next_idx;
            state_d     = S_OUT;
          end
        end
      end
      S_OP: begin
        state_d = S_OUT;
        case (req_q)
          REQ_PIN: begin
            res_pin_d      = fl.pin;
            flag_we        = 1'b1;
            flag_wdata.pin = 1'b1;
          end
          REQ_UNPIN: begin
            flag_we        = 1'b1;
            flag_wdata.pin = 1'b0;
          end
          REQ_FREE: begin
            if (fl.used) begin
              flag_we     = 1'b1;
              flag_wdata  = '{used: 1'b0, pin: fl.pin, acc: 1'b0, dirty: 1'b0};
              res_uv_d    = 1'b1;
              res_vpage_d = pay_rdata[PW-1:OWNER_BITS];
              res_owner_d = pay_rdata[OWNER_BITS-1:0];
            end
          end
          REQ_ACCESS: begin
            if (fl.used) begin
              flag_we          = 1'b1;
              flag_wdata.acc   = 1'b1;
              flag_wdata.dirty = fl.dirty || wr_q;
            end
          end
          default: begin
          end
        endcase
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  ftc_ram #(.Width(FlagW), .Depth(NUM_FRAMES)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .raddr_i (raddr),
    .rdata_o (flag_rdata)
  );

  ftc_ram #(.Width(PW), .Depth(NUM_FRAMES)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (idx_q),
    .wdata_i ({vpage_q, owner_q}),
    .raddr_i (raddr),
    .rdata_o (pay_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      hand_q      <= '0;
      count_q     <= CountW'(64);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hand_q  <= hand_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    evict_q      <= evict_d;
    req_q        <= req_d;
    wr_q         <= wr_d;
    vpage_q      <= vpage_d;
    owner_q      <= owner_d;
    res_status_q <= res_status_d;
    res_frame_q  <= res_frame_d;
    res_pin_q    <= res_pin_d;
    res_uv_q     <= res_uv_d;
    res_vpage_q  <= res_vpage_d;
    res_owner_q  <= res_owner_d;
    res_dirty_q  <= res_dirty_d;
    if (out_load) begin
      status_o      <= res_status_q;
      frame_out_o   <= res_frame_q;
      was_pinned_o  <= res_pin_q;
      unmap_valid_o <= res_uv_q;
      unmap_vpage_o <= res_vpage_q;
      unmap_owner_o <= res_owner_q;
      unmap_dirty_o <= res_dirty_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_evict_ends_sweep,
    (state_q == S_SW_EVAL && fl.used && !fl.pin && !fl.acc) |=> (state_q == S_OUT))
  `ASSERT_NEVER(a_scan_no_evict_unmap,
    (state_q == S_OUT && res_status_q == ST_NO_EVICT && res_uv_q))
  `ASSERT_CLK(a_result_held_until_idle,
    (state_q == S_OUT && !out_load) |=> (state_q == S_OUT && $stable(res_status_q)))

endmodule

// ===== design/ftc_ram.sv =====
module ftc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/ftc_checker.sv =====
`timescale 1ns / 1ps

module ftc_checker
  import ftc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [ReqW-1:0]      req_type_i,
  input  logic [FrameW-1:0]    frame_i,
  input  logic [19:0]          vpage_i,
  input  logic [7:0]           owner_i,
  input  logic                 write_access_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [StatusW-1:0]   status_i,
  input  logic [FrameW-1:0]    frame_out_i,
  input  logic                 was_pinned_i,
  input  logic                 unmap_valid_i,
  input  logic [19:0]          unmap_vpage_i,
  input  logic [7:0]           unmap_owner_i,
  input  logic                 unmap_dirty_i,
  input  logic                 cfg_we_i,
  input  logic [CountW-1:0]    cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output logic                 accepted_o
);

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [FrameW-1:0]  frame_out;
    logic               was_pinned;
    logic               unmap_valid;
    logic [19:0]        unmap_vpage;
    logic [7:0]         unmap_owner;
    logic               unmap_dirty;
  } ftc_result_t;

  logic        used_q [64];
  logic        pin_q [64];
  logic        acc_q [64];
  logic        dirty_q [64];
  logic [19:0] vpage_q [64];
  logic [7:0]  owner_q [64];
  int unsigned hand_q;
  logic [6:0]  count_q;
  ftc_result_t expected_results[$];

  function automatic int unsigned managed_frames();
    if (count_q == 0) return 1;
    if (count_q > 64) return 64;
    return count_q;
  endfunction

  task automatic map_page(int unsigned f, logic [19:0] vp, logic [7:0] own);
    used_q[f] = 1'b1;
    acc_q[f] = 1'b0;
    dirty_q[f] = 1'b0;
    vpage_q[f] = vp;
    owner_q[f] = own;
  endtask

  task automatic apply_request(logic [ReqW-1:0] req, int unsigned f, logic [19:0] vp,
                               logic [7:0] own, logic wr);
    ftc_result_t r;
    int unsigned cnt;
    int unsigned i;
    int unsigned h;
    int          free_idx;
    bit          evictable;
    r = '0;
    cnt = managed_frames();
    if (req == REQ_ALLOC) begin
      free_idx = -1;
      for (i = 0; i < cnt; i++) begin
        if (!used_q[i] && free_idx < 0) free_idx = i;
      end
      if (free_idx >= 0) begin
        map_page(free_idx, vp, own);
        r.frame_out = FrameW'(free_idx);
      end else begin
        evictable = 0;
        for (i = 0; i < cnt; i++) begin
          if (used_q[i] && !pin_q[i]) evictable = 1;
        end
        if (!evictable) begin
          r.status = ST_NO_EVICT;
        end else begin
          h = (hand_q >= cnt) ? 0 : hand_q;
          for (i = 0; i < 2 * cnt + 1; i++) begin
            if (used_q[h] && !pin_q[h]) begin
              if (acc_q[h]) begin
                acc_q[h] = 1'b0;
              end else begin
                r.unmap_valid = 1'b1;
                r.unmap_vpage = vpage_q[h];
                r.unmap_owner = owner_q[h];
                r.unmap_dirty = dirty_q[h];
                map_page(h, vp, own);
                r.frame_out = FrameW'(h);
                h = (h + 1 >= cnt) ? 0 : h + 1;
                break;
              end
            end
            h = (h + 1 >= cnt) ? 0 : h + 1;
          end
          hand_q = h;
        end
      end
    end else if (req inside {REQ_PIN, REQ_UNPIN, REQ_FREE, REQ_ACCESS}) begin
      if (f >= cnt) begin
        r.status = ST_RANGE;
      end else if (req == REQ_PIN) begin
        r.was_pinned = pin_q[f];
        pin_q[f] = 1'b1;
      end else if (req == REQ_UNPIN) begin
        pin_q[f] = 1'b0;
      end else if (req == REQ_FREE) begin
        if (used_q[f]) begin
          r.unmap_valid = 1'b1;
          r.unmap_vpage = vpage_q[f];
          r.unmap_owner = owner_q[f];
          used_q[f] = 1'b0;
          acc_q[f] = 1'b0;
          dirty_q[f] = 1'b0;
        end
      end else if (used_q[f]) begin
        acc_q[f] = 1'b1;
        if (wr) dirty_q[f] = 1'b1;
      end
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_result();
    ftc_result_t w;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", status_i, 0);
      return;
    end
    w = expected_results.pop_front();
    if (status_i !== w.status) report_mismatch("status", status_i, w.status);
    if (frame_out_i !== w.frame_out) report_mismatch("frame_out", frame_out_i, w.frame_out);
    if (was_pinned_i !== w.was_pinned) report_mismatch("was_pinned", was_pinned_i, w.was_pinned);
    if (unmap_valid_i !== w.unmap_valid)
      report_mismatch("unmap_valid", unmap_valid_i, w.unmap_valid);
    if (unmap_vpage_i !== w.unmap_vpage)
      report_mismatch("unmap_vpage", unmap_vpage_i, w.unmap_vpage);
    if (unmap_owner_i !== w.unmap_owner)
      report_mismatch("unmap_owner", unmap_owner_i, w.unmap_owner);
    if (unmap_dirty_i !== w.unmap_dirty)
      report_mismatch("unmap_dirty", unmap_dirty_i, w.unmap_dirty);
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    for (int i = 0; i < 64; i++) begin
      used_q[i] = 0; pin_q[i] = 0; acc_q[i] = 0; dirty_q[i] = 0;
      vpage_q[i] = 0; owner_q[i] = 0;
    end
    hand_q = 0;
    count_q = 7'd64;
  end

  always @(posedge clk_i) begin
    logic seen;
    seen = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) count_q = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        check_result();
        seen = 1'b1;
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(req_type_i, frame_i, vpage_i, owner_i, write_access_i);
        seen = 1'b1;
      end
    end
    pending_o = expected_results.size();
    accepted_o <= seen;
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ftc_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ReqW-1:0]    req_type = '0;
  logic [FrameW-1:0]  frame = '0;
  logic [19:0]        vpage = '0;
  logic [7:0]         owner = '0;
  logic               write_access = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [FrameW-1:0]  frame_out;
  logic               was_pinned;
  logic               unmap_valid;
  logic [19:0]        unmap_vpage;
  logic [7:0]         unmap_owner;
  logic               unmap_dirty;
  logic               cfg_we = 1'b0;
  logic [CountW-1:0]  cfg_wdata = '0;
  int                 fail_count;
  int                 pending;
  logic               accepted;
  bit                 calm_phase = 0;
  bit                 hold_off = 0;
  int                 idle_cycles = 0;
  int                 cur_count = 64;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  frame_table_clock_replacer_core dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .frame_i(frame), .vpage_i(vpage), .owner_i(owner),
    .write_access_i(write_access),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .frame_out_o(frame_out), .was_pinned_o(was_pinned),
    .unmap_valid_o(unmap_valid), .unmap_vpage_o(unmap_vpage),
    .unmap_owner_o(unmap_owner), .unmap_dirty_o(unmap_dirty),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  ftc_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .req_type_i(req_type), .frame_i(frame), .vpage_i(vpage), .owner_i(owner),
    .write_access_i(write_access),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .frame_out_i(frame_out), .was_pinned_i(was_pinned),
    .unmap_valid_i(unmap_valid), .unmap_vpage_i(unmap_vpage),
    .unmap_owner_i(unmap_owner), .unmap_dirty_i(unmap_dirty),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending), .accepted_o(accepted)
  );

  // Receiver: random stalls, except during the calm phase or a forced hold-off.
  always @(posedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else if (calm_phase) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 22);
  end

  always @(posedge clk_i) begin
    if (accepted || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Returns at the accepting edge with valid still high, so a following item
  // can go out back to back.
  task automatic send_request(logic [ReqW-1:0] req, logic [FrameW-1:0] f, logic [19:0] vp,
                              logic [7:0] own, logic wr);
    while (!calm_phase && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= req;
    frame <= f;
    vpage <= vp;
    owner <= own;
    write_access <= wr;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Waits for every expected result, then lets the core idle before returning.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_count(int value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= CountW'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_count = (value == 0) ? 1 : (value > 64 ? 64 : value);
  endtask

  // Most requests target managed frames; allocate dominates so the table fills
  // and the clock sweep runs.
  task automatic random_request();
    int unsigned sel;
    logic [FrameW-1:0] f;
    logic wr;
    sel = $urandom_range(99);
    f = ($urandom_range(9) == 0) ? FrameW'($urandom) : FrameW'($urandom_range(cur_count - 1));
    wr = 1'($urandom);
    if (sel < 40) send_request(REQ_ALLOC, f, 20'($urandom), 8'($urandom), wr);
    else if (sel < 48) send_request(REQ_PIN, f, 20'($urandom), 8'($urandom), wr);
    else if (sel < 58) send_request(REQ_UNPIN, f, 20'($urandom), 8'($urandom), wr);
    else if (sel < 68) send_request(REQ_FREE, f, 20'($urandom), 8'($urandom), wr);
    else if (sel < 97) send_request(REQ_ACCESS, f, 20'($urandom), 8'($urandom), wr);
    else send_request(ReqW'($urandom_range(7, 5)), f, 20'($urandom), 8'($urandom), wr);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill two frames, exercise every request and the corner cases.
    write_count(2);
    send_request(REQ_ALLOC, 0, 20'hFFFFF, 8'hFF, 1'b0);
    send_request(REQ_ALLOC, 0, 20'h00000, 8'h00, 1'b0);
    send_request(REQ_ACCESS, 0, 0, 0, 1'b1);
    send_request(REQ_ALLOC, 0, 20'h12345, 8'hA5, 1'b0);
    send_request(REQ_ALLOC, 0, 20'h54321, 8'h5A, 1'b0);
    send_request(REQ_PIN, 0, 0, 0, 1'b0);
    send_request(REQ_PIN, 0, 0, 0, 1'b0);
    send_request(REQ_PIN, 1, 0, 0, 1'b0);
    send_request(REQ_ALLOC, 0, 20'h11111, 8'h11, 1'b0);
    send_request(REQ_PIN, 6'h3F, 0, 0, 1'b1);
    send_request(REQ_UNPIN, 2, 0, 0, 1'b0);
    send_request(REQ_FREE, 6'h3F, 0, 0, 1'b0);
    send_request(REQ_ACCESS, 6'h3F, 0, 0, 1'b1);
    send_request(REQ_UNPIN, 1, 0, 0, 1'b0);
    send_request(REQ_FREE, 1, 0, 0, 1'b0);
    send_request(REQ_FREE, 1, 0, 0, 1'b0);
    send_request(REQ_ACCESS, 1, 0, 0, 1'b1);
    send_request(REQ_PIN, 1, 0, 0, 1'b0);
    send_request(REQ_ALLOC, 0, 20'h22222, 8'h22, 1'b0);
    send_request(ReqW'(7), 6'h3F, 20'hFFFFF, 8'hFF, 1'b1);
    send_request(ReqW'(5), 0, 0, 0, 1'b0);
    write_count(0);
    send_request(REQ_UNPIN, 0, 0, 0, 1'b0);
    send_request(REQ_ALLOC, 0, 20'h33333, 8'h33, 1'b0);
    write_count(127);
    send_request(REQ_ACCESS, 63, 0, 0, 1'b1);

    // Random phases over several table sizes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_count(64);
        1: write_count(1);
        2: write_count(4);
        3: write_count(100);
        4: write_count($urandom_range(2, 63));
        5: write_count(8);
        6: write_count(0);
        default: write_count(16);
      endcase
      calm_phase = (ph == 5);
      for (int n = 0; n < 210; n++) begin
        if (ph == 2 && n == 100) begin
          fork
            begin
              hold_off = 1;
              repeat (400) @(posedge clk_i);
              hold_off = 0;
            end
          join_none
        end
        if (ph == 3 && n == 100) drain();
        random_request();
      end
    end
    calm_phase = 0;

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
